### design/rtcc_pkg.sv
// ----------------------------------------------------------------------------
// rtcc_pkg: shared types, constants and functions for the RTC calendar block
// Register map, request codes, tick-unit operation codes and calendar helpers.
// ----------------------------------------------------------------------------
package rtcc_pkg;

   // Register file geometry
   localparam int NUM_REGS = 24;
   localparam int IDX_W    = 5;                 // width of the bus offset field
   localparam int ADDR_W   = $clog2(NUM_REGS);  // bits that index the file

   // Fixed counter entries
   localparam logic [IDX_W-1:0] SEC_IDX  = IDX_W'(2);
   localparam logic [IDX_W-1:0] MIN_IDX  = IDX_W'(3);
   localparam logic [IDX_W-1:0] HOUR_IDX = IDX_W'(4);
   localparam logic [IDX_W-1:0] WDAY_IDX = IDX_W'(5);
   localparam logic [IDX_W-1:0] DAY_IDX  = IDX_W'(6);
   localparam logic [IDX_W-1:0] MON_IDX  = IDX_W'(7);
   localparam logic [IDX_W-1:0] YEAR_IDX = IDX_W'(9);

   // Request kinds
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   // Tick unit operations
   typedef enum logic [1:0] {
      OP_BUMP = 2'd0,   // increment, wrap at limit, carry on wrap
      OP_WDAY = 2'd1,   // weekday (w mod 7) + 1, always carries
      OP_YEAR = 2'd2    // (y + 1) mod 100, ends the cascade
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic [7:0] value;
      logic [8:0] limit;
      logic [7:0] wrap_to;
   } alu_req_type;

   typedef struct packed {
      logic [7:0] result;
      logic       carry;
   } alu_rsp_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } rf_write_type;

   // Offset lies inside the register file
   function automatic logic in_range(input logic [IDX_W-1:0] a);
      return ({1'b0, a} < 6'(NUM_REGS));
   endfunction

   // w mod 7 by folding octal digits (8 is 1 mod 7)
   function automatic logic [2:0] mod7(input logic [7:0] w);
      logic [4:0] s1;
      logic [3:0] s2;
      s1 = {2'b00, w[2:0]} + {2'b00, w[5:3]} + {3'b000, w[7:6]};
      s2 = {1'b0, s1[2:0]} + {2'b00, s1[4:3]};
      if (s2 >= 4'd7) begin
         s2 = s2 - 4'd7;
      end
      return s2[2:0];
   endfunction

   // Days in month for year 2000 + yr; months out of range count 31
   function automatic logic [4:0] days_in_month(input logic [7:0] mon, input logic [7:0] yr);
      logic leap;
      // 2000..2255: century years are 2000 (leap), 2100 and 2200 (not leap)
      leap = (yr[1:0] == 2'b00) && (yr != 8'd100) && (yr != 8'd200);
      case (mon)
         8'd2:    days_in_month = leap ? 5'd29 : 5'd28;
         8'd4,
         8'd6,
         8'd9,
         8'd11:   days_in_month = 5'd30;
         default: days_in_month = 5'd31;
      endcase
   endfunction

endpackage

### design/rtcc_alu.sv
// ----------------------------------------------------------------------------
// rtcc_alu: shared counter unit
// One increment / compare / wrap datapath used for every step of the cascade.
// ----------------------------------------------------------------------------
module rtcc_alu
   import rtcc_pkg::*;
(
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   logic [8:0] sum;

   assign sum = {1'b0, alu_req.value} + 9'd1;

   always_comb begin
      alu_rsp = '0;
      case (alu_req.op)
         OP_BUMP: begin
            if (sum >= alu_req.limit) begin
               alu_rsp.result = alu_req.wrap_to;
               alu_rsp.carry  = 1'b1;
            end else begin
               alu_rsp.result = sum[7:0];
               alu_rsp.carry  = 1'b0;
            end
         end
         OP_WDAY: begin
            alu_rsp.result = {5'd0, mod7(alu_req.value)} + 8'd1;
            alu_rsp.carry  = 1'b1;
         end
         OP_YEAR: begin
            // sum is at most 256, so two conditional subtracts suffice
            if (sum >= 9'd200) begin
               alu_rsp.result = 8'(sum - 9'd200);
            end else if (sum >= 9'd100) begin
               alu_rsp.result = 8'(sum - 9'd100);
            end else begin
               alu_rsp.result = sum[7:0];
            end
            alu_rsp.carry = 1'b0;
         end
         default: begin
            alu_rsp = '0;
         end
      endcase
   end

endmodule

### design/rtcc_regfile.sv
// ----------------------------------------------------------------------------
// rtcc_regfile: calendar byte registers
// One write port, one read port; month and year taps feed the day-length test.
// ----------------------------------------------------------------------------
module rtcc_regfile
   import rtcc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  rf_write_type     wr,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [7:0]       rd_data,
   output logic [7:0]       month,
   output logic [7:0]       year
);

   logic [7:0] regs_ff [NUM_REGS];
   logic [7:0] regs_in [NUM_REGS];

   // Write port; offsets beyond the file are dropped
   always_comb begin
      regs_in = regs_ff;
      if (wr.en && in_range(wr.addr)) begin
         regs_in[wr.addr[ADDR_W-1:0]] = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '{default: '0};
      end else begin
         regs_ff <= regs_in;
      end
   end

   // Read port; out-of-range offsets read zero
   assign rd_data = in_range(rd_addr) ? regs_ff[rd_addr[ADDR_W-1:0]] : 8'd0;

   assign month = regs_ff[MON_IDX[ADDR_W-1:0]];
   assign year  = regs_ff[YEAR_IDX[ADDR_W-1:0]];

endmodule

### design/rtc_calendar_register_file_unit.sv
// ----------------------------------------------------------------------------
// rtc_calendar_register_file_unit: real-time clock calendar register file
// Byte register file with a one-second tick that advances the calendar.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries a tick, a read or a write.
//   Response channel (rsp_valid / rsp_stall) returns one byte per read only.
//   A write is stored at the accepting edge.
//   A read first enters the read state; its byte is then loaded into the
//   free output register and stays there until the receiver takes it.
//   A tick enters the tick state and steps the counters from seconds up,
//   ending at the first step without carry or at the year step. The cascade
//   runs through the single shared counter unit, one counter per cycle.
//   req_stall is high while a tick or a read is being worked on.
//   A pending response does not block ticks or writes; a further read waits
//   in its read cycle until the output register is free.
//   Reset clears all 24 registers and any pending response.
// ----------------------------------------------------------------------------
module rtc_calendar_register_file_unit
   import rtcc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_type,
   input  logic [IDX_W-1:0] req_reg_index,
   input  logic [7:0]       req_write_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_read_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_TICK = 3'b010,
      ST_READ = 3'b100
   } state_type;

   // Cascade steps
   localparam logic [2:0] STG_SEC  = 3'd0;
   localparam logic [2:0] STG_MIN  = 3'd1;
   localparam logic [2:0] STG_HOUR = 3'd2;
   localparam logic [2:0] STG_WDAY = 3'd3;
   localparam logic [2:0] STG_DAY  = 3'd4;
   localparam logic [2:0] STG_MON  = 3'd5;
   localparam logic [2:0] STG_YEAR = 3'd6;

   typedef struct packed {
      logic [IDX_W-1:0] addr;
      alu_op_type       op;
      logic [8:0]       limit;
      logic [7:0]       wrap_to;
   } stage_desc_type;

   function automatic stage_desc_type stage_desc(input logic [2:0] stg, input logic [4:0] dim);
      stage_desc_type d;
      d = '{addr: SEC_IDX, op: OP_BUMP, limit: 9'd60, wrap_to: 8'd0};
      case (stg)
         STG_SEC:  d = '{addr: SEC_IDX,  op: OP_BUMP, limit: 9'd60, wrap_to: 8'd0};
         STG_MIN:  d = '{addr: MIN_IDX,  op: OP_BUMP, limit: 9'd60, wrap_to: 8'd0};
         STG_HOUR: d = '{addr: HOUR_IDX, op: OP_BUMP, limit: 9'd24, wrap_to: 8'd0};
         STG_WDAY: d = '{addr: WDAY_IDX, op: OP_WDAY, limit: 9'd0,  wrap_to: 8'd0};
         STG_DAY:  d = '{addr: DAY_IDX,  op: OP_BUMP, limit: {4'd0, dim} + 9'd1,
                         wrap_to: 8'd1};
         STG_MON:  d = '{addr: MON_IDX,  op: OP_BUMP, limit: 9'd13, wrap_to: 8'd1};
         STG_YEAR: d = '{addr: YEAR_IDX, op: OP_YEAR, limit: 9'd0,  wrap_to: 8'd0};
         default:  d = '{addr: SEC_IDX,  op: OP_BUMP, limit: 9'd60, wrap_to: 8'd0};
      endcase
      return d;
   endfunction

   state_type        state_ff, state_in;
   logic [2:0]       stage_ff, stage_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;

   logic             req_accept;
   logic             rsp_free;
   stage_desc_type   desc;
   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;
   rf_write_type     rf_wr;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   logic [7:0]       month;
   logic [7:0]       year;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_accept    = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;

   // Current cascade step and shared unit operands
   assign desc    = stage_desc(stage_ff, days_in_month(month, year));
   assign rd_addr = (state_ff == ST_TICK) ? desc.addr : idx_ff;
   assign alu_req = '{op: desc.op, value: rd_data, limit: desc.limit, wrap_to: desc.wrap_to};

   rtcc_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // Write port: bus writes from idle, counter updates from the cascade
   always_comb begin
      rf_wr = '0;
      if (req_accept && (req_type == REQ_WRITE)) begin
         rf_wr = '{en: 1'b1, addr: req_reg_index, data: req_write_data};
      end else if (state_ff == ST_TICK) begin
         rf_wr = '{en: 1'b1, addr: desc.addr, data: alu_rsp.result};
      end
   end

   rtcc_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr      (rf_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .month   (month),
      .year    (year)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_type)
                  REQ_TICK: begin
                     state_in = ST_TICK;
                     stage_in = STG_SEC;
                  end
                  REQ_READ: begin
                     state_in = ST_READ;
                     idx_in   = req_reg_index;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (!alu_rsp.carry || (stage_ff == STG_YEAR)) begin
               state_in = ST_IDLE;
            end else begin
               stage_in = stage_ff + 3'd1;
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_data;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= STG_SEC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // Requests are only taken while the sequencer is idle
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == ST_IDLE))
      else $error("request accepted while busy");

   // Cascade never runs past the year step
   a_stage_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |-> (stage_ff <= STG_YEAR))
      else $error("cascade step out of range");

   // A step without carry ends the tick
   a_tick_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK && !alu_rsp.carry) |=> (state_ff == ST_IDLE))
      else $error("tick did not end on missing carry");

   // A read with a free output register produces a response next cycle
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("read response not delivered");
`endif

endmodule
